@@ hw/rtl/fixed_partition_fit_allocator_top_defines.svh @@
// assertion macros shared by the allocator modules
// needs clk and arst_n in the scope of each use
`ifndef FIXED_PARTITION_FIT_ALLOCATOR_TOP_DEFINES_SVH
`define FIXED_PARTITION_FIT_ALLOCATOR_TOP_DEFINES_SVH

// same-cycle implication, reset masked
`define FPFA_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("allocator assertion failed");

// next-cycle implication, reset masked
`define FPFA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("allocator assertion failed");

`endif

@@ hw/rtl/fpfa_pkg.sv @@
// shared types and constants for the fixed-partition fit allocator
// no dependencies
package fpfa_pkg;

	localparam int DEF_NUM_PARTS = 16;

	localparam int SIZE_W      = 16;
	localparam int BLK_IDX_W   = 4;
	localparam int BLK_NUM_W   = 5;
	localparam int NUM_BLKS_W  = 5;
	localparam int POLICY_W    = 2;
	localparam int REQ_W       = 2;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 8;

	localparam logic [CFG_IDX_W-1:0] REG_NUM_BLOCKS = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_FIT_POLICY = CFG_IDX_W'(1);

	typedef enum logic [REQ_W-1:0] {
		REQ_LOAD    = 2'd0,
		REQ_ALLOC   = 2'd1,
		REQ_RELEASE = 2'd2
	} req_t;

	typedef enum logic [POLICY_W-1:0] {
		POL_FIRST = 2'd0,
		POL_BEST  = 2'd1,
		POL_WORST = 2'd2
	} policy_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic scan;
		logic commit;
	} fpfa_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic in_alloc;
		logic scan_done;
	} fpfa_stat_t;

endpackage

@@ hw/rtl/fpfa_ram.sv @@
// generic single-write, single-read ram with registered read data
// no dependencies
module fpfa_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ hw/rtl/fpfa_dp.sv @@
// allocator datapath: size table, busy marks, scan counter, compare stage, result register
// depends on fpfa_pkg, fpfa_ram and the assertion macro header
`include "fixed_partition_fit_allocator_top_defines.svh"

module fpfa_dp import fpfa_pkg::*; #(
	parameter int NUM_PARTS = DEF_NUM_PARTS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  fpfa_cmd_t             cmd,
	output fpfa_stat_t            st,
	input  logic [REQ_W-1:0]      req_type,
	input  logic [BLK_IDX_W-1:0]  block_index,
	input  logic [SIZE_W-1:0]     value,
	input  logic [NUM_BLKS_W-1:0] num_blocks,
	input  logic [POLICY_W-1:0]   fit_policy,
	output logic                  granted,
	output logic [BLK_NUM_W-1:0]  block_number,
	output logic [SIZE_W-1:0]     remaining
);

	localparam int IDXW = $clog2(NUM_PARTS);
	localparam int CNTW = $clog2(NUM_PARTS + 1);

	logic [SIZE_W-1:0]    val_q;
	logic [CNTW-1:0]      n_q;
	logic [CNTW-1:0]      n_next;
	logic [CNTW-1:0]      rd_k_q;
	logic                 cmp_valid_s1;
	logic [IDXW-1:0]      cmp_k_s1;
	logic                 found_q;
	logic [IDXW-1:0]      pick_q;
	logic [SIZE_W-1:0]    best_q;
	logic [NUM_PARTS-1:0] busy_q;
	logic                 granted_q;
	logic [BLK_NUM_W-1:0] block_number_q;
	logic [SIZE_W-1:0]    remaining_q;

	logic                 ram_we;
	logic                 issue;
	logic [SIZE_W-1:0]    ram_rdata;
	logic                 fits;
	logic                 take;

	// partitions in use, saturated to the table depth
	always_comb begin
		if (32'(num_blocks) > NUM_PARTS) begin
			n_next = CNTW'(NUM_PARTS);
		end else begin
			n_next = CNTW'(num_blocks);
		end
	end

	assign ram_we = cmd.accept && (req_type == REQ_LOAD) && (32'(block_index) < NUM_PARTS);
	assign issue  = cmd.scan && (rd_k_q != n_q);

	fpfa_ram #(
		.WIDTH (SIZE_W),
		.DEPTH (NUM_PARTS)
	) u_size_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (IDXW'(block_index)),
		.wdata (value),
		.re    (issue),
		.raddr (rd_k_q[IDXW-1:0]),
		.rdata (ram_rdata)
	);

	// compare stage, ties keep the lower partition
	always_comb begin
		fits = !busy_q[cmp_k_s1] && (ram_rdata >= val_q);
		take = 1'b0;
		if (cmp_valid_s1 && fits) begin
			if (!found_q) begin
				take = 1'b1;
			end else if (fit_policy == POL_BEST) begin
				take = ram_rdata < best_q;
			end else if (fit_policy == POL_WORST) begin
				take = ram_rdata > best_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q          <= '0;
			rd_k_q       <= '0;
			cmp_valid_s1 <= 1'b0;
			found_q      <= 1'b0;
			busy_q       <= '0;
		end else begin
			cmp_valid_s1 <= issue;
			if (cmd.accept) begin
				n_q     <= n_next;
				rd_k_q  <= '0;
				found_q <= 1'b0;
				if (req_type == REQ_RELEASE) begin
					busy_q <= '0;
				end
			end else begin
				if (issue) begin
					rd_k_q <= rd_k_q + CNTW'(1);
				end
				if (take) begin
					found_q <= 1'b1;
				end
				if (cmd.commit && found_q) begin
					busy_q[pick_q] <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			val_q <= value;
		end
		if (issue) begin
			cmp_k_s1 <= rd_k_q[IDXW-1:0];
		end
		if (take) begin
			pick_q <= cmp_k_s1;
			best_q <= ram_rdata;
		end
		if (cmd.commit) begin
			granted_q      <= found_q;
			block_number_q <= found_q ? BLK_NUM_W'(pick_q) + BLK_NUM_W'(1) : '0;
			remaining_q    <= found_q ? best_q - val_q : '0;
		end
	end

	assign st.in_alloc  = (req_type == REQ_ALLOC);
	assign st.scan_done = (rd_k_q == n_q) && !cmp_valid_s1;

	assign granted      = granted_q;
	assign block_number = block_number_q;
	assign remaining    = remaining_q;

	`FPFA_ASSERT_IMPL(a_pick_in_range, found_q, CNTW'(pick_q) < n_q)
	`FPFA_ASSERT_NEXT(a_grant_marks_busy, cmd.commit && found_q, busy_q[$past(pick_q)])

endmodule

@@ hw/rtl/fpfa_ctrl.sv @@
// allocator controller: request sequencing and output handshake
// depends on fpfa_pkg and the assertion macro header
`include "fixed_partition_fit_allocator_top_defines.svh"

module fpfa_ctrl import fpfa_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  fpfa_stat_t st,
	output fpfa_cmd_t  cmd
);

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SCAN   = 3'b010,
		ST_RESULT = 3'b100
	} state_t;

	state_t state_q;
	state_t state_next;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_next = state_q;
		cmd        = '0;
		in_ready   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
				if (in_valid) begin
					state_next = st.in_alloc ? ST_SCAN : ST_RESULT;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (st.scan_done) begin
					state_next = ST_RESULT;
				end
			end
			ST_RESULT: begin
				// result register must be empty or emptying
				if (out_free) begin
					cmd.commit = 1'b1;
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	`FPFA_ASSERT_IMPL(a_commit_when_free, cmd.commit, !out_valid_q || out_ready)
	`FPFA_ASSERT_NEXT(a_plain_request_to_result, cmd.accept && !st.in_alloc, state_q == ST_RESULT)
	`FPFA_ASSERT_NEXT(a_scan_exit, state_q == ST_SCAN && st.scan_done, state_q == ST_RESULT)

endmodule

@@ hw/rtl/fixed_partition_fit_allocator_top.sv @@
// Fixed-partition fit allocator. Load requests fill a table of NUM_PARTS partition
// sizes, allocate requests take one free partition chosen by first, best or worst fit
// (ties to the lower number), and release requests clear every busy mark. Each request
// gives one result. An allocate scans the first n partitions, n being num_blocks
// saturated to NUM_PARTS, through a single registered ram read port, one partition a
// cycle; a new request is taken only after the last one has been committed to the
// output register. A finished result sits in that output register, so the next request
// can be taken while it waits. The configuration port is always ready.
module fixed_partition_fit_allocator_top import fpfa_pkg::*; #(
	parameter int NUM_PARTS = DEF_NUM_PARTS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [REQ_W-1:0]      req_type,
	input  logic [BLK_IDX_W-1:0]  block_index,
	input  logic [SIZE_W-1:0]     value,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  granted,
	output logic [BLK_NUM_W-1:0]  block_number,
	output logic [SIZE_W-1:0]     remaining
);

	logic [NUM_BLKS_W-1:0] num_blocks_q;
	logic [POLICY_W-1:0]   fit_policy_q;
	fpfa_cmd_t             cmd;
	fpfa_stat_t            st;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_blocks_q <= '0;
			fit_policy_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_NUM_BLOCKS: num_blocks_q <= cfg_data[NUM_BLKS_W-1:0];
				REG_FIT_POLICY: fit_policy_q <= cfg_data[POLICY_W-1:0];
				default: begin
				end
			endcase
		end
	end

	fpfa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.st        (st),
		.cmd       (cmd)
	);

	fpfa_dp #(
		.NUM_PARTS (NUM_PARTS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.st           (st),
		.req_type     (req_type),
		.block_index  (block_index),
		.value        (value),
		.num_blocks   (num_blocks_q),
		.fit_policy   (fit_policy_q),
		.granted      (granted),
		.block_number (block_number),
		.remaining    (remaining)
	);

endmodule

@@ tb/fixed_partition_fit_allocator_top_tb.sv @@
// self-checking testbench for fixed_partition_fit_allocator_top: first, best and worst fit
// against a behavioural table model, directed corner cases then constrained random traffic
// depends on fpfa_pkg and the allocator rtl
module fixed_partition_fit_allocator_top_tb;
	import fpfa_pkg::*;

	localparam int NUM_PARTS   = DEF_NUM_PARTS;
	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_WAIT  = 40;
	localparam int RANDOM_REQS = 1100;
	localparam int CALM_FROM   = 950;
	localparam int MAX_PRINTS  = 100;

	// codes the package leaves unnamed
	localparam logic [REQ_W-1:0]     REQ_NOP     = 2'd3;
	localparam logic [POLICY_W-1:0]  POL_SPARE   = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

	typedef struct packed {
		logic                 granted;
		logic [BLK_NUM_W-1:0] block_number;
		logic [SIZE_W-1:0]    remaining;
	} alloc_result_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic [REQ_W-1:0]      req_type;
	logic [BLK_IDX_W-1:0]  block_index;
	logic [SIZE_W-1:0]     value;
	logic                  out_valid;
	logic                  out_ready;
	logic                  granted;
	logic [BLK_NUM_W-1:0]  block_number;
	logic [SIZE_W-1:0]     remaining;

	// shadow copy of the allocator state
	logic [SIZE_W-1:0]     part_size_q [NUM_PARTS];
	logic                  part_busy_q [NUM_PARTS];
	logic [NUM_BLKS_W-1:0] blocks_q;
	logic [POLICY_W-1:0]   policy_q;

	alloc_result_t pending_grants[$];
	int            fail_count;
	int            requests_sent;
	int            quiet_cycles;
	int            stall_left;
	bit            gaps_on;

	fixed_partition_fit_allocator_top #(
		.NUM_PARTS(NUM_PARTS)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.req_type    (req_type),
		.block_index (block_index),
		.value       (value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.granted     (granted),
		.block_number(block_number),
		.remaining   (remaining)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// works out the result of one request and updates the shadow table
	function automatic alloc_result_t allocator_outcome(logic [REQ_W-1:0] kind,
			logic [BLK_IDX_W-1:0] idx, logic [SIZE_W-1:0] val);
		alloc_result_t r;
		int            n;
		int            pick;
		bit            found;
		r = '0;
		found = 1'b0;
		pick = 0;
		case (kind)
			REQ_LOAD: begin
				part_size_q[idx] = val;
			end
			REQ_RELEASE: begin
				for (int k = 0; k < NUM_PARTS; k++)
					part_busy_q[k] = 1'b0;
			end
			REQ_ALLOC: begin
				n = (blocks_q > NUM_PARTS) ? NUM_PARTS : int'(blocks_q);
				for (int k = 0; k < n; k++) begin
					if (part_busy_q[k] || part_size_q[k] < val)
						continue;
					if (!found) begin
						found = 1'b1;
						pick = k;
						if (policy_q != POL_BEST && policy_q != POL_WORST)
							break;
					end else if (policy_q == POL_BEST && part_size_q[k] < part_size_q[pick]) begin
						pick = k;
					end else if (policy_q == POL_WORST && part_size_q[k] > part_size_q[pick]) begin
						pick = k;
					end
				end
				if (found) begin
					part_busy_q[pick] = 1'b1;
					r.granted = 1'b1;
					r.block_number = BLK_NUM_W'(pick + 1);
					r.remaining = part_size_q[pick] - val;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		if (fail_count < MAX_PRINTS)
			$display("mismatch on %s: got %0d, expected %0d", what, got, want);
		fail_count++;
	endtask

	// sends one request, optionally after a short gap
	task automatic send_request(input logic [REQ_W-1:0] kind, input logic [BLK_IDX_W-1:0] idx,
			input logic [SIZE_W-1:0] val);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid    <= 1'b1;
		req_type    <= kind;
		block_index <= idx;
		value       <= val;
		do @(posedge clk); while (!in_ready);
		pending_grants.push_back(allocator_outcome(kind, idx, val));
		requests_sent++;
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_grants.size() != 0)
			@(posedge clk);
	endtask

	// writes both registers back to back, with the spare indexes touched first if asked
	task automatic set_config(input logic [CFG_DATA_W-1:0] nb_data,
			input logic [CFG_DATA_W-1:0] pol_data, input bit touch_spare);
		logic [CFG_IDX_W-1:0]  idx_list [4];
		logic [CFG_DATA_W-1:0] data_list [4];
		int                    first;
		idx_list  = '{REG_SPARE_A, REG_SPARE_B, REG_NUM_BLOCKS, REG_FIT_POLICY};
		data_list = '{CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), nb_data, pol_data};
		first = touch_spare ? 0 : 2;
		wait_idle();
		for (int w = first; w < 4; w++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx_list[w];
			cfg_data  <= data_list[w];
			do @(posedge clk); while (!cfg_ready);
			if (idx_list[w] == REG_NUM_BLOCKS)
				blocks_q = data_list[w][NUM_BLKS_W-1:0];
			else if (idx_list[w] == REG_FIT_POLICY)
				policy_q = data_list[w][POLICY_W-1:0];
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic test_first_fit();
		set_config(8'd4, 8'(POL_FIRST), 1'b1);
		send_request(REQ_LOAD, 4'd0, 16'd100);
		send_request(REQ_LOAD, 4'd1, 16'hffff);
		send_request(REQ_LOAD, 4'd2, 16'd0);
		send_request(REQ_LOAD, 4'd3, 16'd300);
		send_request(REQ_ALLOC, 4'd0, 16'd0);
		send_request(REQ_ALLOC, 4'd0, 16'hffff);
		send_request(REQ_ALLOC, 4'd0, 16'd200);
		// only the zero sized partition is left, so no fit
		send_request(REQ_ALLOC, 4'd0, 16'd1);
	endtask

	task automatic test_best_fit();
		send_request(REQ_RELEASE, 4'd0, 16'd0);
		set_config(8'd4, 8'(POL_BEST), 1'b0);
		// equal sizes in entries 0 and 3, the lower one must win
		send_request(REQ_LOAD, 4'd3, 16'd100);
		send_request(REQ_ALLOC, 4'd0, 16'd100);
		send_request(REQ_ALLOC, 4'd0, 16'd50);
		send_request(REQ_ALLOC, 4'd0, 16'd50);
	endtask

	task automatic test_worst_fit();
		send_request(REQ_RELEASE, 4'd0, 16'd0);
		set_config(8'd4, 8'(POL_WORST), 1'b0);
		send_request(REQ_ALLOC, 4'd0, 16'd50);
		send_request(REQ_ALLOC, 4'd0, 16'd50);
		send_request(REQ_ALLOC, 4'd0, 16'd100);
		send_request(REQ_ALLOC, 4'd0, 16'd0);
	endtask

	task automatic test_spare_codes();
		send_request(REQ_RELEASE, 4'd0, 16'd0);
		set_config(8'd4, 8'(POL_SPARE), 1'b1);
		send_request(REQ_ALLOC, 4'd0, 16'd50);
		send_request(REQ_NOP, 4'd15, 16'hffff);
		send_request(REQ_LOAD, 4'd15, 16'haaaa);
		set_config(8'd0, 8'(POL_FIRST), 1'b0);
		send_request(REQ_ALLOC, 4'd0, 16'd0);
	endtask

	task automatic test_random_traffic();
		logic [NUM_BLKS_W-1:0] nb;
		logic [POLICY_W-1:0]   pol;
		logic [SIZE_W-1:0]     sz;
		int                    batch;
		int                    pct;
		int                    k;
		batch = 0;
		set_config(8'd16, 8'(POL_FIRST), 1'b0);
		// fill the whole table so that any partition count is legal from here on
		for (int i = 0; i < NUM_PARTS; i++) begin
			sz = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 4095)) : 16'($urandom);
			send_request(REQ_LOAD, 4'(i), sz);
		end
		while (requests_sent < RANDOM_REQS) begin
			case (batch)
				0: nb = 5'd31;
				1: nb = 5'd16;
				2: nb = 5'd0;
				3: nb = 5'd1;
				4: nb = 5'd17;
				default: nb = ($urandom_range(0, 2) == 0) ? 5'd16 : 5'($urandom_range(0, 31));
			endcase
			pol = POLICY_W'($urandom_range(0, 3));
			gaps_on = (requests_sent < CALM_FROM) && ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 1) == 0)
				set_config({3'($urandom), nb}, {6'($urandom), pol}, $urandom_range(0, 3) == 0);
			else
				set_config(8'(nb), 8'(pol), 1'b0);
			repeat ($urandom_range(15, 40)) begin
				pct = $urandom_range(0, 99);
				k = $urandom_range(0, NUM_PARTS - 1);
				if (pct < 8) begin
					send_request(REQ_RELEASE, 4'($urandom), 16'($urandom));
				end else if (pct < 10) begin
					send_request(REQ_NOP, 4'($urandom), 16'($urandom));
				end else if (pct < 22) begin
					// loads often copy another entry so that ties come up
					case ($urandom_range(0, 2))
						0: sz = 16'($urandom);
						1: sz = 16'($urandom_range(0, 4095));
						default: sz = part_size_q[$urandom_range(0, NUM_PARTS - 1)];
					endcase
					send_request(REQ_LOAD, 4'(k), sz);
				end else begin
					pct = $urandom_range(0, 9);
					if (pct < 4)
						sz = 16'($urandom_range(0, 4095));
					else if (pct < 6)
						sz = 16'($urandom);
					else if (pct < 9)
						sz = (part_size_q[k] > 16'd3) ?
							part_size_q[k] - 16'($urandom_range(0, 3)) : part_size_q[k];
					else
						sz = 16'd0;
					send_request(REQ_ALLOC, 4'($urandom), sz);
				end
				if (requests_sent >= CALM_FROM)
					gaps_on = 1'b0;
			end
			batch++;
		end
	endtask

	// result side: random back-pressure in bursts
	always @(posedge clk) begin
		if (!gaps_on) begin
			out_ready <= 1'b1;
			stall_left = 0;
		end else if (stall_left != 0) begin
			out_ready <= 1'b0;
			stall_left--;
		end else if ($urandom_range(0, 3) == 0) begin
			out_ready <= 1'b0;
			stall_left = $urandom_range(1, 4) - 1;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin : check_results
		alloc_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_grants.size() == 0) begin
				report_mismatch("unrequested result, block_number", block_number, 0);
			end else begin
				want = pending_grants.pop_front();
				if (granted !== want.granted)
					report_mismatch("granted", granted, want.granted);
				if (block_number !== want.block_number)
					report_mismatch("block_number", block_number, want.block_number);
				if (remaining !== want.remaining)
					report_mismatch("remaining", remaining, want.remaining);
			end
		end
	end

	// ends the run if no request moves on any channel for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("fixed_partition_fit_allocator_top_tb failed");
			$finish;
		end
	end

	initial begin
		arst_n       = 1'b0;
		cfg_valid    = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		in_valid     = 1'b0;
		req_type     = '0;
		block_index  = '0;
		value        = '0;
		out_ready    = 1'b0;
		fail_count   = 0;
		requests_sent = 0;
		quiet_cycles = 0;
		stall_left   = 0;
		gaps_on      = 1'b1;
		blocks_q     = '0;
		policy_q     = '0;
		for (int i = 0; i < NUM_PARTS; i++) begin
			part_size_q[i] = '0;
			part_busy_q[i] = 1'b0;
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		test_first_fit();
		test_best_fit();
		test_worst_fit();
		test_spare_codes();
		test_random_traffic();

		wait_idle();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (fail_count == 0)
			$display("fixed_partition_fit_allocator_top_tb passed");
		else
			$display("fixed_partition_fit_allocator_top_tb failed");
		$finish;
	end

endmodule
